FILE: rtl/exyz_pkg.sv
// ----------------------------------------------------------------------------
// Euler XYZ rotation package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package exyz_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF      = 16;
	localparam int TRIG_FRAC           = 30;
	localparam int CORDIC_STEPS        = 30;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	function automatic logic signed [31:0] atan_turn(input int i);
		logic [29:0] t [0:29];
		t = '{30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
		      30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
		      30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
		      30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001};
		return signed'({2'b00, t[i]});
	endfunction

endpackage

FILE: rtl/euler_xyz_vector_rotation.sv
// ----------------------------------------------------------------------------
// Euler XYZ vector rotation
// Rotates a Q16.16 point about X, then Y, then Z with CORDIC trig.
// ----------------------------------------------------------------------------
// Pipeline: CORDIC trig first, then per axis a multiply, add and
// round/saturate stage, for X, then Y, then Z.
// Throughput: one beat per cycle; busy is always low.
// Reset clears the valid pipeline; data registers are not reset.
module euler_xyz_vector_rotation import exyz_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int ANGLE_BITS      = ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic [15:0]        angle_x,
	input  logic [15:0]        angle_y,
	input  logic [15:0]        angle_z,
	output logic               out_valid,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	// Trig latency plus the three rotation stages.
	localparam int TL  = CORDIC_STEPS + 2;
	localparam int LAT = TL + 9;

	typedef logic signed [31:0] c_t;
	typedef logic signed [TRIG_FRAC+1:0] tr_t;

	logic [LAT-1:0] vld_q;
	c_t  px_q [0:TL-1];
	c_t  py_q [0:TL-1];
	c_t  pz_q [0:TL-1];
	tr_t cx, sx, cy, sy, cz, sz;
	logic [15:0] ay_q [0:2];
	logic [15:0] az_q [0:5];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end
	assign out_valid = vld_q[LAT-1];

	// Y and Z angles are delayed so each trig result meets its axis stage.
	always_ff @(posedge clk) begin
		ay_q[0] <= angle_y;
		ay_q[1] <= ay_q[0];
		ay_q[2] <= ay_q[1];
		az_q[0] <= angle_z;
		for (int i = 1; i < 6; i++) az_q[i] <= az_q[i-1];
		px_q[0] <= in_x;
		py_q[0] <= in_y;
		pz_q[0] <= in_z;
		for (int i = 1; i < TL; i++) begin
			px_q[i] <= px_q[i-1];
			py_q[i] <= py_q[i-1];
			pz_q[i] <= pz_q[i-1];
		end
	end

	exyz_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_x (
		.clk(clk), .angle(angle_x), .cos_v(cx), .sin_v(sx));
	exyz_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_y (
		.clk(clk), .angle(ay_q[2]), .cos_v(cy), .sin_v(sy));
	exyz_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_z (
		.clk(clk), .angle(az_q[5]), .cos_v(cz), .sin_v(sz));

	function automatic c_t rnd_sat(input logic signed [65:0] s);
		logic signed [65:0] r;
		r = (s + (66'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
		if (r > 66'sd2147483647)       return 32'sh7FFFFFFF;
		else if (r < -66'sd2147483648) return 32'sh80000000;
		else                           return 32'(r);
	endfunction

	// Stage X: products, sums, round.
	logic signed [63:0] xa_s1, xb_s1, xc_s1, xd_s1;
	c_t                 xx_s1, xx_s2;
	logic signed [65:0] xy_s2, xz_s2;
	c_t                 xx_s3, xy_s3, xz_s3;
	always_ff @(posedge clk) begin
		xa_s1 <= py_q[TL-1] * cx;
		xb_s1 <= pz_q[TL-1] * sx;
		xc_s1 <= pz_q[TL-1] * cx;
		xd_s1 <= py_q[TL-1] * sx;
		xx_s1 <= px_q[TL-1];
		xy_s2 <= 66'(xa_s1) + 66'(xb_s1);
		xz_s2 <= 66'(xc_s1) - 66'(xd_s1);
		xx_s2 <= xx_s1;
		xy_s3 <= rnd_sat(xy_s2);
		xz_s3 <= rnd_sat(xz_s2);
		xx_s3 <= xx_s2;
	end

	// Stage Y.
	logic signed [63:0] ya_s1, yb_s1, yc_s1, yd_s1;
	c_t                 yy_s1, yy_s2;
	logic signed [65:0] yx_s2, yz_s2;
	c_t                 yx_s3, yy_s3, yz_s3;
	always_ff @(posedge clk) begin
		ya_s1 <= xx_s3 * cy;
		yb_s1 <= xz_s3 * sy;
		yc_s1 <= xx_s3 * sy;
		yd_s1 <= xz_s3 * cy;
		yy_s1 <= xy_s3;
		yx_s2 <= 66'(ya_s1) - 66'(yb_s1);
		yz_s2 <= 66'(yc_s1) + 66'(yd_s1);
		yy_s2 <= yy_s1;
		yx_s3 <= rnd_sat(yx_s2);
		yz_s3 <= rnd_sat(yz_s2);
		yy_s3 <= yy_s2;
	end

	// Stage Z.
	logic signed [63:0] za_s1, zb_s1, zc_s1, zd_s1;
	c_t                 zz_s1, zz_s2;
	logic signed [65:0] zx_s2, zy_s2;
	always_ff @(posedge clk) begin
		za_s1 <= yx_s3 * cz;
		zb_s1 <= yy_s3 * sz;
		zc_s1 <= yy_s3 * cz;
		zd_s1 <= yx_s3 * sz;
		zz_s1 <= yz_s3;
		zx_s2 <= 66'(za_s1) + 66'(zb_s1);
		zy_s2 <= 66'(zc_s1) - 66'(zd_s1);
		zz_s2 <= zz_s1;
		out_x <= rnd_sat(zx_s2);
		out_y <= rnd_sat(zy_s2);
		out_z <= zz_s2;
	end
endmodule

FILE: rtl/exyz_trig.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine/cosine
// One CORDIC iteration per stage; quadrant applied at the end.
// One angle per cycle.
// ----------------------------------------------------------------------------
module exyz_trig import exyz_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic [15:0]               angle,
	output logic signed [TRIG_FRAC+1:0] cos_v,
	output logic signed [TRIG_FRAC+1:0] sin_v
);
	localparam int AW = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

	logic [31:0]        a;
	logic [1:0]         q_in;
	logic signed [31:0] r_in;

	logic signed [33:0] x_s [0:CORDIC_STEPS];
	logic signed [33:0] y_s [0:CORDIC_STEPS];
	logic signed [31:0] r_s [0:CORDIC_STEPS];
	logic [1:0]         q_s [0:CORDIC_STEPS];

	always_comb begin
		a = 32'(angle[AW-1:0]) << (32 - ANGLE_BITS);
		if (a[29]) begin
			q_in = a[31:30] + 2'd1;
			r_in = signed'({2'b00, a[29:0]}) - 32'sh40000000;
		end else begin
			q_in = a[31:30];
			r_in = signed'({2'b00, a[29:0]});
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= CORDIC_GAIN;
		y_s[0] <= '0;
		r_s[0] <= r_in;
		q_s[0] <= q_in;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (r_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				r_s[i+1] <= r_s[i] - atan_turn(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				r_s[i+1] <= r_s[i] + atan_turn(i);
			end
			q_s[i+1] <= q_s[i];
		end
	end

	always_ff @(posedge clk) begin
		case (q_s[CORDIC_STEPS])
			2'd0:    begin cos_v <= 32'(x_s[CORDIC_STEPS]);  sin_v <= 32'(y_s[CORDIC_STEPS]);  end
			2'd1:    begin cos_v <= 32'(-y_s[CORDIC_STEPS]); sin_v <= 32'(x_s[CORDIC_STEPS]);  end
			2'd2:    begin cos_v <= 32'(-x_s[CORDIC_STEPS]); sin_v <= 32'(-y_s[CORDIC_STEPS]); end
			default: begin cos_v <= 32'(y_s[CORDIC_STEPS]);  sin_v <= 32'(-x_s[CORDIC_STEPS]); end
		endcase
	end
endmodule
